// ===== hw/rtl/spse_pkg.sv =====
// ============================================================================
// spse_pkg: shared definitions for the sparsity pattern stencil engine
// Field widths, command codes, the memory request bundle and a popcount helper.
// ============================================================================
`default_nettype none

package spse_pkg;

  // Storage geometry.
  localparam int MAX_ROWS   = 64;
  localparam int ADDR_W     = $clog2(MAX_ROWS);
  localparam int ROW_BITS_W = 64;

  // Field widths of the channels.
  localparam int CMD_W  = 3;
  localparam int ROW_W  = 6;
  localparam int COL_W  = 6;
  localparam int RND_W  = 4;
  localparam int POS_W  = 13;
  localparam int SIZE_W = 7;
  localparam int CFG_W  = 7;

  localparam logic [CFG_W-1:0] ROW_COUNT_RESET = CFG_W'(64);

  // Command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR   = 3'd0,
    CMD_INSERT  = 3'd1,
    CMD_ENLARGE = 3'd2,
    CMD_READ    = 3'd3,
    CMD_FIND    = 3'd4
  } cmd_t;

  // One port of a row memory: a write and a read in the same cycle.
  typedef struct packed {
    logic                  we;
    logic [ADDR_W-1:0]     waddr;
    logic [ROW_BITS_W-1:0] wdata;
    logic [ADDR_W-1:0]     raddr;
  } ram_req_t;

  // Number of set bits in a row bitmap.
  function automatic logic [SIZE_W-1:0] popcount(input logic [ROW_BITS_W-1:0] v);
    logic [SIZE_W-1:0] c;
    c = '0;
    for (int k = 0; k < ROW_BITS_W; k++) begin
      c = c + SIZE_W'(v[k]);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/spse_if.sv =====
// ============================================================================
// spse_if: request, response and configuration channels
// Valid/ready channels; a request moves when valid and ready are both high.
// ============================================================================
`default_nettype none

interface spse_in_if;
  logic                       valid;
  logic                       ready;
  logic [spse_pkg::CMD_W-1:0] command;
  logic [spse_pkg::ROW_W-1:0] row;
  logic [spse_pkg::COL_W-1:0] column;
  logic [spse_pkg::RND_W-1:0] rounds;

  modport source (output valid, command, row, column, rounds, input ready);
  modport sink   (input valid, command, row, column, rounds, output ready);
endinterface

interface spse_out_if;
  logic                            valid;
  logic                            ready;
  logic                            status;
  logic [spse_pkg::ROW_BITS_W-1:0] row_bits;
  logic [spse_pkg::POS_W-1:0]      position;
  logic [spse_pkg::SIZE_W-1:0]     row_size;

  modport source (output valid, status, row_bits, position, row_size, input ready);
  modport sink   (input valid, status, row_bits, position, row_size, output ready);
endinterface

interface spse_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [spse_pkg::CFG_W-1:0] row_count;

  modport source (output valid, row_count, input ready);
  modport sink   (input valid, row_count, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/spse_ram.sv =====
// ============================================================================
// spse_ram: simple dual-port synchronous RAM
// One write port and one read port; read data is registered.
// ============================================================================
`default_nettype none

module spse_ram #(
  parameter int DATA_W = 64,
  parameter int ADDR_W = 6,
  parameter int DEPTH  = 64
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hw/rtl/spse_ctrl.sv =====
// ============================================================================
// spse_ctrl: command sequencer for the sparsity pattern stencil engine
// Walks the row memories for insert, read, find and stencil enlargement, and
// holds the response register.
// ============================================================================
`default_nettype none

module spse_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [spse_pkg::CFG_W-1:0]      row_count,
  spse_in_if.sink                         in_req,
  spse_out_if.source                      out_rsp,
  output spse_pkg::ram_req_t              pat_req,
  output spse_pkg::ram_req_t              add_req,
  input  logic [spse_pkg::ROW_BITS_W-1:0] pat_rdata,
  input  logic [spse_pkg::ROW_BITS_W-1:0] add_rdata
);
  import spse_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_INS_WR = 10'b00_0000_0010,
    S_SCAN   = 10'b00_0000_0100,
    S_FIN    = 10'b00_0000_1000,
    S_EN_ROW = 10'b00_0001_0000,
    S_EN_NB  = 10'b00_0010_0000,
    S_EN_ACC = 10'b00_0100_0000,
    S_AP_RD  = 10'b00_1000_0000,
    S_AP_WR  = 10'b01_0000_0000,
    S_RESP   = 10'b10_0000_0000
  } state_t;

  state_t                state_r, state_nxt;
  logic                  is_read_r, is_read_nxt;
  logic [ADDR_W-1:0]     row_r, row_nxt;
  logic [COL_W-1:0]      col_r, col_nxt;
  logic [RND_W-1:0]      rounds_r, rounds_nxt;
  logic [ADDR_W-1:0]     i_r, i_nxt;
  logic [ADDR_W-1:0]     j_r, j_nxt;
  logic [ADDR_W-1:0]     issue_r, issue_nxt;
  logic                  data_ok_r, data_ok_nxt;
  logic [ADDR_W-1:0]     data_idx_r, data_idx_nxt;
  logic [ROW_BITS_W-1:0] nb_r, nb_nxt;
  logic [ROW_BITS_W-1:0] acc_r, acc_nxt;
  logic [POS_W-1:0]      start_r, start_nxt;
  logic [ROW_BITS_W-1:0] bits_r, bits_nxt;
  logic [MAX_ROWS-1:0]   valid_r, valid_nxt;
  logic                  rvalid_r;

  logic                  res_status_r, res_status_nxt;
  logic [ROW_BITS_W-1:0] res_bits_r, res_bits_nxt;
  logic [POS_W-1:0]      res_pos_r, res_pos_nxt;
  logic [SIZE_W-1:0]     res_size_r, res_size_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_status_r, out_status_nxt;
  logic [ROW_BITS_W-1:0] out_bits_r, out_bits_nxt;
  logic [POS_W-1:0]      out_pos_r, out_pos_nxt;
  logic [SIZE_W-1:0]     out_size_r, out_size_nxt;

  logic [CFG_W-1:0]      n_live;
  logic [ROW_BITS_W-1:0] live_mask;
  logic [ROW_BITS_W-1:0] pat_rd;
  logic [ROW_BITS_W-1:0] row_d;
  logic [ROW_BITS_W-1:0] acc_v;
  logic [ROW_BITS_W-1:0] below;
  logic                  row_ok;
  logic                  col_ok;
  logic                  j_last;
  logic                  i_last;

  // Live region: rows and columns below the clamped row count.
  assign n_live = (row_count > CFG_W'(MAX_ROWS)) ? CFG_W'(MAX_ROWS) : row_count;

  always_comb begin
    for (int b = 0; b < ROW_BITS_W; b++) begin
      live_mask[b] = (CFG_W'(b) < n_live);
    end
  end

  // A row that was never written since the last clear reads as empty.
  assign pat_rd = rvalid_r ? pat_rdata : '0;
  assign row_d  = pat_rd & live_mask;
  assign acc_v  = acc_r | (nb_r[j_r] ? row_d : '0);
  assign below  = bits_r & ((ROW_BITS_W'(1) << col_r) - ROW_BITS_W'(1));

  assign row_ok = (CFG_W'(in_req.row) < n_live);
  assign col_ok = (CFG_W'(in_req.column) < n_live);
  assign j_last = ((CFG_W'(j_r) + CFG_W'(1)) == n_live);
  assign i_last = ((CFG_W'(i_r) + CFG_W'(1)) == n_live);

  assign in_req.ready     = (state_r == S_IDLE);
  assign out_rsp.valid    = out_valid_r;
  assign out_rsp.status   = out_status_r;
  assign out_rsp.row_bits = out_bits_r;
  assign out_rsp.position = out_pos_r;
  assign out_rsp.row_size = out_size_r;

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    is_read_nxt    = is_read_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    rounds_nxt     = rounds_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    issue_nxt      = issue_r;
    data_ok_nxt    = 1'b0;
    data_idx_nxt   = data_idx_r;
    nb_nxt         = nb_r;
    acc_nxt        = acc_r;
    start_nxt      = start_r;
    bits_nxt       = bits_r;
    valid_nxt      = valid_r;
    res_status_nxt = res_status_r;
    res_bits_nxt   = res_bits_r;
    res_pos_nxt    = res_pos_r;
    res_size_nxt   = res_size_r;
    out_valid_nxt  = out_valid_r & ~out_rsp.ready;
    out_status_nxt = out_status_r;
    out_bits_nxt   = out_bits_r;
    out_pos_nxt    = out_pos_r;
    out_size_nxt   = out_size_r;

    pat_req        = '0;
    pat_req.raddr  = in_req.row[ADDR_W-1:0];
    add_req        = '0;
    add_req.raddr  = i_r;

    case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          is_read_nxt    = (in_req.command == CMD_READ);
          row_nxt        = in_req.row[ADDR_W-1:0];
          col_nxt        = in_req.column;
          rounds_nxt     = in_req.rounds;
          res_status_nxt = 1'b0;
          res_bits_nxt   = '0;
          res_pos_nxt    = '0;
          res_size_nxt   = '0;
          state_nxt      = S_RESP;
          case (in_req.command)
            CMD_CLEAR: begin
              valid_nxt = '0;
            end
            CMD_INSERT: begin
              // The row read issued this cycle is merged next cycle.
              if (row_ok && col_ok) begin
                state_nxt = S_INS_WR;
              end else begin
                res_status_nxt = 1'b1;
              end
            end
            CMD_ENLARGE: begin
              if (in_req.rounds != '0 && n_live != '0) begin
                i_nxt     = '0;
                state_nxt = S_EN_ROW;
              end
            end
            CMD_READ: begin
              if (row_ok) begin
                issue_nxt = '0;
                start_nxt = '0;
                state_nxt = S_SCAN;
              end else begin
                res_status_nxt = 1'b1;
              end
            end
            CMD_FIND: begin
              if (row_ok && col_ok) begin
                issue_nxt = '0;
                start_nxt = '0;
                state_nxt = S_SCAN;
              end else begin
                res_status_nxt = 1'b1;
              end
            end
            default: begin
              res_status_nxt = 1'b1;
            end
          endcase
        end
      end

      S_INS_WR: begin
        pat_req.we     = 1'b1;
        pat_req.waddr  = row_r;
        pat_req.wdata  = pat_rd | (ROW_BITS_W'(1) << col_r);
        valid_nxt[row_r] = 1'b1;
        state_nxt      = S_RESP;
      end

      // Stream rows from the top, summing live entries above the target row.
      S_SCAN: begin
        pat_req.raddr = issue_r;
        issue_nxt     = issue_r + ADDR_W'(1);
        data_ok_nxt   = 1'b1;
        data_idx_nxt  = issue_r;
        if (data_ok_r) begin
          if (data_idx_r < row_r) begin
            start_nxt = start_r + POS_W'(popcount(row_d));
          end else if (data_idx_r == row_r) begin
            bits_nxt    = row_d;
            data_ok_nxt = 1'b0;
            state_nxt   = S_FIN;
          end
        end
      end

      // Size of the target row and, for a find, the offset inside it.
      S_FIN: begin
        res_size_nxt = popcount(bits_r);
        if (is_read_r) begin
          res_bits_nxt = bits_r;
          res_pos_nxt  = start_r;
        end else if (bits_r[col_r]) begin
          res_pos_nxt = start_r + POS_W'(popcount(below));
        end else begin
          res_status_nxt = 1'b1;
        end
        state_nxt = S_RESP;
      end

      // Enlargement: fetch the neighbour set of row i.
      S_EN_ROW: begin
        pat_req.raddr = i_r;
        state_nxt     = S_EN_NB;
      end

      S_EN_NB: begin
        nb_nxt        = row_d;
        acc_nxt       = '0;
        j_nxt         = '0;
        pat_req.raddr = '0;
        state_nxt     = S_EN_ACC;
      end

      // Stream rows j and gather the union of the neighbour rows.
      S_EN_ACC: begin
        if (j_last) begin
          add_req.we    = 1'b1;
          add_req.waddr = i_r;
          add_req.wdata = acc_v;
          if (i_last) begin
            i_nxt     = '0;
            state_nxt = S_AP_RD;
          end else begin
            i_nxt     = i_r + ADDR_W'(1);
            state_nxt = S_EN_ROW;
          end
        end else begin
          j_nxt         = j_r + ADDR_W'(1);
          pat_req.raddr = j_r + ADDR_W'(1);
          acc_nxt       = acc_v;
        end
      end

      // Fold the round's additions into the pattern.
      S_AP_RD: begin
        pat_req.raddr = i_r;
        state_nxt     = S_AP_WR;
      end

      S_AP_WR: begin
        pat_req.we     = 1'b1;
        pat_req.waddr  = i_r;
        pat_req.wdata  = pat_rd | add_rdata;
        valid_nxt[i_r] = 1'b1;
        if (i_last) begin
          i_nxt      = '0;
          rounds_nxt = rounds_r - RND_W'(1);
          if (rounds_r == RND_W'(1)) begin
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_EN_ROW;
          end
        end else begin
          i_nxt     = i_r + ADDR_W'(1);
          state_nxt = S_AP_RD;
        end
      end

      // Hand the result to the output register once it is free.
      S_RESP: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_bits_nxt   = res_bits_r;
          out_pos_nxt    = res_pos_r;
          out_size_nxt   = res_size_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      data_ok_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      data_ok_r   <= data_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    is_read_r    <= is_read_nxt;
    row_r        <= row_nxt;
    col_r        <= col_nxt;
    rounds_r     <= rounds_nxt;
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    issue_r      <= issue_nxt;
    data_idx_r   <= data_idx_nxt;
    nb_r         <= nb_nxt;
    acc_r        <= acc_nxt;
    start_r      <= start_nxt;
    bits_r       <= bits_nxt;
    rvalid_r     <= valid_r[pat_req.raddr];
    res_status_r <= res_status_nxt;
    res_bits_r   <= res_bits_nxt;
    res_pos_r    <= res_pos_nxt;
    res_size_r   <= res_size_nxt;
    out_status_r <= out_status_nxt;
    out_bits_r   <= out_bits_nxt;
    out_pos_r    <= out_pos_nxt;
    out_size_r   <= out_size_nxt;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sparsity_pattern_stencil_engine.sv =====
// ============================================================================
// sparsity_pattern_stencil_engine: bitmap sparsity pattern with stencil growth
// Stores one 64-bit column bitmap per matrix row and serves clear, insert,
// enlarge, read-row and find-entry requests with compressed-row positions.
// ============================================================================
//
//  Channel   Dir   Handshake      Carries
//  in_req    in    valid/ready    command, row, column, rounds
//  out_rsp   out   valid/ready    status, row_bits, position, row_size
//  cfg_wr    in    valid/ready    row_count (always ready)
//
// One request is worked on at a time; a new one is taken while the previous
// response still waits in the output register. Read and find make one memory
// read per row from the top down to the target row; enlarge is bound by the
// single read port of the pattern memory. Reset empties the pattern at once
// through per-row valid bits. A stalled output holds the sequencer.
// ============================================================================
`default_nettype none

module sparsity_pattern_stencil_engine (
  input  logic       clk,
  input  logic       rst_n,
  spse_in_if.sink    in_req,
  spse_out_if.source out_rsp,
  spse_cfg_if.sink   cfg_wr
);
  import spse_pkg::*;

  logic [CFG_W-1:0]      row_count_r;
  ram_req_t              pat_req;
  ram_req_t              add_req;
  logic [ROW_BITS_W-1:0] pat_rdata;
  logic [ROW_BITS_W-1:0] add_rdata;

  // Row count register.
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= ROW_COUNT_RESET;
    end else if (cfg_wr.valid) begin
      row_count_r <= cfg_wr.row_count;
    end
  end

  // Sequencer.
  spse_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .row_count (row_count_r),
    .in_req    (in_req),
    .out_rsp   (out_rsp),
    .pat_req   (pat_req),
    .add_req   (add_req),
    .pat_rdata (pat_rdata),
    .add_rdata (add_rdata)
  );

  // Pattern rows.
  spse_ram #(
    .DATA_W (ROW_BITS_W),
    .ADDR_W (ADDR_W),
    .DEPTH  (MAX_ROWS)
  ) u_pat_ram (
    .clk   (clk),
    .we    (pat_req.we),
    .waddr (pat_req.waddr),
    .wdata (pat_req.wdata),
    .raddr (pat_req.raddr),
    .rdata (pat_rdata)
  );

  // Per-round additions.
  spse_ram #(
    .DATA_W (ROW_BITS_W),
    .ADDR_W (ADDR_W),
    .DEPTH  (MAX_ROWS)
  ) u_add_ram (
    .clk   (clk),
    .we    (add_req.we),
    .waddr (add_req.waddr),
    .wdata (add_req.wdata),
    .raddr (add_req.raddr),
    .rdata (add_rdata)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/spse_checker.sv =====
// ============================================================================
// spse_checker: port-level checks for the sparsity pattern stencil engine
// Watches the request and response channels and is bound to the top level.
// ============================================================================
`default_nettype none

module spse_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            out_status,
  input logic [spse_pkg::ROW_BITS_W-1:0] out_row_bits,
  input logic [spse_pkg::SIZE_W-1:0]     out_row_size
);
  import spse_pkg::*;

  // A stalled response keeps its bitmap.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_row_bits))
    else $error("response changed while stalled");

  // One request at a time: the block is busy right after taking one.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while previous one in flight");

  // A failed request never returns a bitmap.
  a_err_no_bits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_row_bits == '0)
    else $error("error response carries row bits");

  // A row never holds more entries than there are columns.
  a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_row_size <= SIZE_W'(MAX_ROWS))
    else $error("row size out of range");

endmodule

bind sparsity_pattern_stencil_engine spse_checker u_spse_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_req.valid),
  .in_ready     (in_req.ready),
  .out_valid    (out_rsp.valid),
  .out_ready    (out_rsp.ready),
  .out_status   (out_rsp.status),
  .out_row_bits (out_rsp.row_bits),
  .out_row_size (out_rsp.row_size)
);

`default_nettype wire
